// ----- src/xbc_pkg.sv -----
// xbc_pkg: shared types, constants and the crc-16 byte update for the
// xmodem block checker. no dependencies.
`timescale 1ns / 1ps

package xbc_pkg;

  localparam logic [7:0]  HDR_SOH  = 8'h01;
  localparam logic [7:0]  HDR_STX  = 8'h02;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // result queue depth, room for two results of one transfer at a time
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // verdict codes; the first three double as the per-frame failure code
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_HEADER     = 3'd1,
    ST_BAD_COMPLEMENT = 3'd2,
    ST_TOO_SHORT      = 3'd3,
    ST_CRC_MISMATCH   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } xbc_in_t;

  typedef struct packed {
    logic       is_verdict;
    logic [7:0] payload_byte;
    logic [9:0] payload_index;
    logic       frame_ok;
    logic [7:0] block_number;
    status_e    status;
    logic       run_final;
  } xbc_out_t;

  // results of one accepted byte: up to two, in order
  typedef struct packed {
    logic [1:0] cnt;
    xbc_out_t   res0;
    xbc_out_t   res1;
  } xbc_push_t;

  // crc-16/xmodem, msb first, one byte
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- src/xbc_parser.sv -----
// xbc_parser: frame state registers and the per-byte step logic.
// depends on xbc_pkg.
`timescale 1ns / 1ps

module xbc_parser import xbc_pkg::*; #(
  parameter int unsigned SMALL_BLOCK = 128,
  parameter int unsigned LARGE_BLOCK = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  xbc_in_t   in_data_i,
  output xbc_push_t push_o
);

  localparam int unsigned MAX_BLK = (SMALL_BLOCK > LARGE_BLOCK) ? SMALL_BLOCK : LARGE_BLOCK;
  localparam int unsigned POS_W   = $clog2(MAX_BLK + 6);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             large_q, large_d;
  logic [7:0]       blk_q, blk_d;
  status_e          fail_q, fail_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       hi_q, hi_d;
  logic             match_q, match_d;

  logic [POS_W-1:0] size;
  logic [7:0]       b;
  logic             last;
  logic             pay;
  status_e          st;
  xbc_out_t         r_pay, r_ver;

  assign b    = in_data_i.rx_byte;
  assign last = in_data_i.frame_end;

  always_comb begin
    large_d = large_q;
    blk_d   = blk_q;
    fail_d  = fail_q;
    crc_d   = crc_q;
    hi_d    = hi_q;
    match_d = match_q;
    pay     = 1'b0;

    // header picks the block size
    if (pos_q == '0) begin
      large_d = (b == HDR_STX);
      if (b != HDR_STX && b != HDR_SOH) begin
        fail_d = ST_BAD_HEADER;
      end
    end
    size = large_d ? POS_W'(LARGE_BLOCK) : POS_W'(SMALL_BLOCK);

    if (pos_q == '0) begin
      // handled above
    end else if (pos_q == POS_W'(1)) begin
      blk_d = b;
    end else if (pos_q == POS_W'(2)) begin
      if (fail_q == ST_OK && (8'hFF - blk_q) != b) begin
        fail_d = ST_BAD_COMPLEMENT;
      end
    end else if (pos_q < size + POS_W'(3)) begin
      crc_d = crc16_update(crc_q, b);
      pay   = (fail_q != ST_BAD_HEADER);
    end else if (pos_q == size + POS_W'(3)) begin
      hi_d = b;
    end else if (pos_q == size + POS_W'(4)) begin
      match_d = ({hi_q, b} == crc_q);
    end

    // saturates one past the crc
    pos_d = (pos_q < size + POS_W'(5)) ? pos_q + POS_W'(1) : pos_q;

    if (fail_d == ST_BAD_HEADER) begin
      st = ST_BAD_HEADER;
    end else if (pos_d < size + POS_W'(5)) begin
      st = ST_TOO_SHORT;
    end else if (fail_d == ST_BAD_COMPLEMENT) begin
      st = ST_BAD_COMPLEMENT;
    end else if (!match_d) begin
      st = ST_CRC_MISMATCH;
    end else begin
      st = ST_OK;
    end

    r_pay               = '0;
    r_pay.payload_byte  = b;
    r_pay.payload_index = 10'(pos_q - POS_W'(3));
    r_pay.status        = ST_OK;
    r_pay.run_final     = !last;

    r_ver              = '0;
    r_ver.is_verdict   = 1'b1;
    r_ver.frame_ok     = (st == ST_OK);
    r_ver.block_number = blk_d;
    r_ver.status       = st;
    r_ver.run_final    = 1'b1;

    push_o.cnt  = accept_i ? (2'(pay) + 2'(last)) : 2'd0;
    push_o.res0 = pay ? r_pay : r_ver;
    push_o.res1 = r_ver;

    // verdict closes the frame
    if (last) begin
      pos_d   = '0;
      large_d = 1'b0;
      blk_d   = '0;
      fail_d  = ST_OK;
      crc_d   = '0;
      hi_d    = '0;
      match_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      large_q <= 1'b0;
      blk_q   <= '0;
      fail_q  <= ST_OK;
      crc_q   <= '0;
      hi_q    <= '0;
      match_q <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      large_q <= large_d;
      blk_q   <= blk_d;
      fail_q  <= fail_d;
      crc_q   <= crc_d;
      hi_q    <= hi_d;
      match_q <= match_d;
    end
  end

endmodule

// ----- src/xbc_result_queue.sv -----
// xbc_result_queue: small result queue, up to two writes and one read per cycle.
// depends on xbc_pkg.
`timescale 1ns / 1ps

module xbc_result_queue import xbc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  xbc_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output xbc_out_t  out_data_o
);

  xbc_out_t              mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [RQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));

  assign wr_d  = wr_q + RQ_PTR_W'(push_i.cnt);
  assign rd_d  = rd_q + RQ_PTR_W'(pop);
  assign cnt_d = cnt_q + RQ_CNT_W'(push_i.cnt) - RQ_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wr_q + RQ_PTR_W'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> (cnt_q + RQ_CNT_W'(push_i.cnt) <= RQ_CNT_W'(RQ_DEPTH)))
    else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_q == wr_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ----- src/xmodem_block_checker.sv -----
// xmodem_block_checker: top level, byte parser feeding a result queue.
// depends on xbc_pkg, xbc_parser, xbc_result_queue.
`timescale 1ns / 1ps

// Checks one received XMODEM frame (SOH/128 or STX/1K data block, CRC-16)
// fed one byte per input transfer, with frame_end on the frame's last byte.
// Each data byte of a frame with a good header is queued as a payload result;
// the last byte also yields a verdict with block number and status.
// The block takes one byte per cycle as long as each byte produces at most
// one result and the output side does not stall. A byte that ends a frame
// inside its data block produces two results; the four-entry result queue,
// drained one result per cycle while the output does not stall, absorbs that
// and in_stall_o rises only when fewer than two queue slots are free.
// Payload results of a frame whose verdict is not ok must be discarded.
module xmodem_block_checker import xbc_pkg::*; #(
  parameter int unsigned SMALL_BLOCK = 128,
  parameter int unsigned LARGE_BLOCK = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // byte input
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  xbc_in_t  in_data_i,
  // result output
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output xbc_out_t out_data_o
);

  logic      accept;
  logic      room;
  xbc_push_t push;

  // stall comes from the registered queue count only
  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  // per-byte step: header, block number, complement, crc, verdict
  xbc_parser #(
    .SMALL_BLOCK (SMALL_BLOCK),
    .LARGE_BLOCK (LARGE_BLOCK)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  // results wait here until the consumer takes them, one per transfer
  xbc_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_verdict_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_verdict) |-> out_data_o.run_final)
    else $error("verdict not marked as last result");

  a_ok_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_verdict) |->
      (out_data_o.frame_ok == (out_data_o.status == ST_OK)))
    else $error("frame_ok disagrees with status");

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> accept)
    else $error("results written without an input transfer");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for xmodem_block_checker, a directed table of
// short frames followed by random whole frames, checked against a built-in model.
// depends on xbc_pkg and xmodem_block_checker.
`timescale 1ns / 1ps

module tb_top;
  import xbc_pkg::*;

  localparam int unsigned SMALL_LEN  = 128;
  localparam int unsigned LARGE_LEN  = 1024;
  localparam int unsigned RAND_ITEMS = 800;
  localparam int unsigned IDLE_LIMIT = 500;  // cycles without any transfer
  localparam int unsigned DRAIN_WAIT = 16;   // quiet cycles at the end

  // one row of the directed table; a typed verdict overrides the model's one
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
    logic       typed;
    status_e    st;
    logic [7:0] blk;
  } frame_row_t;

  typedef enum logic [2:0] {
    FK_GOOD, FK_BAD_COMP, FK_BAD_CRC, FK_CUT, FK_BAD_HDR, FK_LARGE
  } frame_kind_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  xbc_in_t    in_data;
  frame_row_t in_note;   // travels with in_data, carries the typed verdict
  logic       out_valid;
  logic       out_stall;
  xbc_out_t   out_data;
  logic       calm;      // no idling on either side while high

  always #5 clk_i = ~clk_i;

  xmodem_block_checker #(
    .SMALL_BLOCK(SMALL_LEN),
    .LARGE_BLOCK(LARGE_LEN)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // ---------------------------------------------------------------------------
  // frame parser model: its own copy of the per-frame state
  // ---------------------------------------------------------------------------
  int unsigned seen_cnt;     // bytes of this frame so far, stops past the crc
  logic        is_large;
  logic [7:0]  hdr_blk;
  status_e     early_fail;   // header or complement failure, ST_OK if none
  logic [15:0] data_crc;
  logic [7:0]  rx_crc_hi;
  logic        crc_good;

  xbc_out_t results_due[$];  // results still owed by the block, oldest first

  int unsigned n_fail;
  int unsigned n_bytes;
  int unsigned n_payload;
  int unsigned n_verdict;
  int unsigned n_ok;

  // crc-16/xmodem, one data bit at a time, msb first
  function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ d[k];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic clear_frame();
    seen_cnt   = 0;
    is_large   = 1'b0;
    hdr_blk    = 8'h00;
    early_fail = ST_OK;
    data_crc   = 16'h0000;
    rx_crc_hi  = 8'h00;
    crc_good   = 1'b0;
  endtask

  // work out the results of one received byte and queue them
  task automatic parse_byte(input xbc_in_t it);
    int unsigned blk_len;
    xbc_out_t    r;
    status_e     st;
    blk_len = is_large ? LARGE_LEN : SMALL_LEN;
    if (seen_cnt == 0) begin
      // header byte picks the block size, anything but soh/stx is fatal
      is_large = (it.rx_byte == HDR_STX);
      if (it.rx_byte != HDR_STX && it.rx_byte != HDR_SOH) early_fail = ST_BAD_HEADER;
      blk_len = is_large ? LARGE_LEN : SMALL_LEN;
    end else if (seen_cnt == 1) begin
      hdr_blk = it.rx_byte;
    end else if (seen_cnt == 2) begin
      if (early_fail == ST_OK && ~hdr_blk != it.rx_byte) early_fail = ST_BAD_COMPLEMENT;
    end else if (seen_cnt < 3 + blk_len) begin
      data_crc = crc_next(data_crc, it.rx_byte);
      // data still goes out after a bad complement, never after a bad header
      if (early_fail != ST_BAD_HEADER) begin
        r               = '0;
        r.payload_byte  = it.rx_byte;
        r.payload_index = 10'(seen_cnt - 3);
        r.run_final     = !it.frame_end;
        results_due.push_back(r);
      end
    end else if (seen_cnt == 3 + blk_len) begin
      rx_crc_hi = it.rx_byte;
    end else if (seen_cnt == 4 + blk_len) begin
      crc_good = ({rx_crc_hi, it.rx_byte} == data_crc);
    end
    // trailing bytes past the crc change nothing
    if (seen_cnt < 5 + blk_len) seen_cnt++;

    if (it.frame_end) begin
      // bad header beats too short, which beats bad complement, then crc
      if (early_fail == ST_BAD_HEADER)  st = ST_BAD_HEADER;
      else if (seen_cnt < 5 + blk_len)  st = ST_TOO_SHORT;
      else if (early_fail != ST_OK)     st = early_fail;
      else if (!crc_good)               st = ST_CRC_MISMATCH;
      else                              st = ST_OK;
      r              = '0;
      r.is_verdict   = 1'b1;
      r.frame_ok     = (st == ST_OK);
      r.block_number = hdr_blk;
      r.status       = st;
      r.run_final    = 1'b1;
      results_due.push_back(r);
      clear_frame();
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      n_fail++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: predict on every byte transfer, check every result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    xbc_out_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        n_bytes++;
        parse_byte(in_data);
        if (in_note.typed) begin
          // the verdict is the newest result of a frame-ending byte
          want              = '0;
          want.is_verdict   = 1'b1;
          want.frame_ok     = (in_note.st == ST_OK);
          want.block_number = in_note.blk;
          want.status       = in_note.st;
          want.run_final    = 1'b1;
          results_due[results_due.size() - 1] = want;
        end
      end
      if (out_valid && !out_stall) begin
        if (out_data.is_verdict) begin
          n_verdict++;
          if (out_data.frame_ok) n_ok++;
        end else begin
          n_payload++;
        end
        if (results_due.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_data);
          n_fail++;
        end else begin
          want = results_due.pop_front();
          check_field("is_verdict", want.is_verdict, out_data.is_verdict);
          check_field("payload_byte", want.payload_byte, out_data.payload_byte);
          check_field("payload_index", want.payload_index, out_data.payload_index);
          check_field("frame_ok", want.frame_ok, out_data.frame_ok);
          check_field("block_number", want.block_number, out_data.block_number);
          check_field("status", want.status, out_data.status);
          check_field("run_final", want.run_final, out_data.run_final);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a run that stops moving is a failure
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               idle_cycles, results_due.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // alternate stretches of random idling with stretches of none
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk_i);
      calm <= ~calm;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: while not calm, a random stall before each transfer
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned wait_cyc;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_cyc = calm ? 0 : $urandom_range(0, 4);
      if (wait_cyc != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cyc) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------
  // present one byte after a random gap and hold it until the transfer;
  // valid stays high on return so back-to-back bytes need no extra step
  task automatic send_byte(input logic [7:0] b, input logic fin, input frame_row_t note);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid          <= 1'b1;
    in_data.rx_byte   <= b;
    in_data.frame_end <= fin;
    in_note           <= note;
    do @(posedge clk_i); while (in_stall);
  endtask

  // short frames with plain verdicts: header failures, too-short ends on the
  // header, block number, complement or data, and the check order between them
  frame_row_t directed_tbl [23] = '{
    '{8'h00, 1'b1, 1'b1, ST_BAD_HEADER, 8'h00},  // lone bad header byte
    '{8'hFF, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h12, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'hED, 1'b1, 1'b1, ST_BAD_HEADER, 8'h12},  // bad header, complement fine
    '{8'h01, 1'b1, 1'b1, ST_TOO_SHORT,  8'h00},  // soh alone
    '{8'h02, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h7E, 1'b1, 1'b1, ST_TOO_SHORT,  8'h7E},  // ends on the block number
    '{8'h02, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h00, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'hFF, 1'b1, 1'b1, ST_TOO_SHORT,  8'h00},  // stx, ends on complement
    '{8'h01, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'hFF, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h00, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'hAB, 1'b1, 1'b1, ST_TOO_SHORT,  8'hFF},  // payload then verdict
    '{8'h01, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h05, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h05, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h55, 1'b1, 1'b1, ST_TOO_SHORT,  8'h05},  // too short beats complement
    '{8'h03, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h01, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'hFE, 1'b0, 1'b0, ST_OK,         8'h00},
    '{8'h80, 1'b0, 1'b0, ST_OK,         8'h00},  // data after bad header: silent
    '{8'h7F, 1'b1, 1'b1, ST_BAD_HEADER, 8'h01}
  };

  initial begin
    logic [7:0]  frame_bytes[$];
    frame_kind_e kind;
    frame_row_t  no_note;
    logic [7:0]  hdr;
    logic [7:0]  blk;
    logic [7:0]  d;
    logic [15:0] crc;
    int unsigned blk_len;
    int unsigned cut;
    int unsigned n_sent;
    logic        did_large;

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    in_note   = '0;
    no_note   = '0;
    n_fail    = 0;
    n_bytes   = 0;
    n_payload = 0;
    n_verdict = 0;
    n_ok      = 0;
    n_sent    = 0;
    did_large = 1'b0;
    clear_frame();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) begin
      send_byte(directed_tbl[i].rx_byte, directed_tbl[i].frame_end, directed_tbl[i]);
    end

    // random whole frames: mostly well formed with random content, plus
    // corrupted, cut short and garbage frames; one full 1k block on the way
    while (n_sent < RAND_ITEMS || !did_large) begin
      case ($urandom_range(0, 9))
        5:       kind = FK_BAD_COMP;
        6:       kind = FK_BAD_CRC;
        7:       kind = FK_CUT;
        8:       kind = FK_BAD_HDR;
        default: kind = FK_GOOD;
      endcase
      if (!did_large && n_sent > 300) kind = FK_LARGE;
      frame_bytes.delete();

      if (kind == FK_BAD_HDR) begin
        // anything but soh or stx up front, then a few random bytes
        do hdr = 8'($urandom_range(0, 255)); while (hdr == HDR_SOH || hdr == HDR_STX);
        frame_bytes.push_back(hdr);
        repeat ($urandom_range(0, 9)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        hdr     = (kind == FK_LARGE) ? HDR_STX : HDR_SOH;
        blk_len = (kind == FK_LARGE) ? LARGE_LEN : SMALL_LEN;
        if (kind == FK_LARGE) did_large = 1'b1;
        blk = 8'($urandom_range(0, 255));
        frame_bytes.push_back(hdr);
        frame_bytes.push_back(blk);
        if (kind == FK_BAD_COMP)
          frame_bytes.push_back(~blk ^ (8'h01 << $urandom_range(0, 7)));
        else
          frame_bytes.push_back(~blk);
        crc = 16'h0000;
        repeat (blk_len) begin
          d   = 8'($urandom_range(0, 255));
          crc = crc_next(crc, d);
          frame_bytes.push_back(d);
        end
        if (kind == FK_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        // bytes past the crc are ignored by the block
        repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        if (kind == FK_CUT) begin
          cut = $urandom_range(1, frame_bytes.size() - 1);
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
      end

      foreach (frame_bytes[i]) begin
        send_byte(frame_bytes[i], i == frame_bytes.size() - 1, no_note);
        n_sent++;
      end
    end
    in_valid <= 1'b0;

    // let every owed result come out, then watch for strays
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d byte transfers: %0d payload results, %0d verdicts (%0d ok)",
             n_bytes, n_payload, n_verdict, n_ok);
    $display("frames of both block sizes, with bad headers, complements, crcs and cut ends");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
